// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files
// Clocked property checks with asynchronous reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/ufb_pkg.sv =====
// ----------------------------------------------------------------------------
// ufb_pkg
// Types and constants of the UART FIFO bridge register block.
// ----------------------------------------------------------------------------
package ufb_pkg;

	localparam int DATA_W = 8;
	localparam int MODE_W = 3;

	localparam int FIFO_DEPTH_DEF = 256;
	localparam int MAX_MODE_DEF   = 1;

	// Kind of item presented to the block
	typedef enum logic [1:0] {
		REQ_HOST_RD = 2'd0,
		REQ_HOST_WR = 2'd1,
		REQ_LINK_RX = 2'd2,
		REQ_LINK_TX = 2'd3
	} req_kind_t;

	// Register map
	localparam logic [DATA_W-1:0] REG_DATA_LIM = 8'hBF;
	localparam logic [DATA_W-1:0] REG_IN_USED  = 8'hC0;
	localparam logic [DATA_W-1:0] REG_OUT_FREE = 8'hC1;
	localparam logic [DATA_W-1:0] REG_CMD      = 8'hC7;

	// Command codes
	localparam logic [DATA_W-1:0] CMD_MODE_MASK  = 8'hF8;
	localparam logic [DATA_W-1:0] CMD_MODE_CODE  = 8'hF0;
	localparam logic [DATA_W-1:0] CMD_VERSION    = 8'hFF;
	localparam logic [DATA_W-1:0] CMD_CLEAR_MASK = 8'hFC;
	localparam int                CMD_CLR_IN_BIT  = 0;
	localparam int                CMD_CLR_OUT_BIT = 1;

	// Result codes and read filler
	localparam logic [DATA_W-1:0] RESULT_OK      = 8'h00;
	localparam logic [DATA_W-1:0] RESULT_VERSION = 8'h01;
	localparam logic [DATA_W-1:0] RESULT_RESET   = 8'hFF;
	localparam logic [DATA_W-1:0] RD_NONE        = 8'hFF;

	// Modes
	localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DATA = 3'd1;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
	} ctrl_cmd_t;

endpackage

// ===== hdl/ufb_req_if.sv =====
// ----------------------------------------------------------------------------
// ufb_req_if
// Request channel: one host access or link event per word.
// ----------------------------------------------------------------------------
interface ufb_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  req_type;
	logic [ufb_pkg::DATA_W-1:0]  reg_index;
	logic [ufb_pkg::DATA_W-1:0]  wr_data;
	logic [ufb_pkg::DATA_W-1:0]  link_byte;

	modport source (output valid, req_type, reg_index, wr_data, link_byte, input ready);
	modport sink   (input valid, req_type, reg_index, wr_data, link_byte, output ready);
endinterface

// ===== hdl/ufb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ufb_rsp_if
// Response channel: one result word per request.
// ----------------------------------------------------------------------------
interface ufb_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ufb_pkg::DATA_W-1:0]  read_data;
	logic                        tx_valid;
	logic [ufb_pkg::DATA_W-1:0]  tx_byte;
	logic                        rx_accepted;

	modport source (output valid, read_data, tx_valid, tx_byte, rx_accepted, input ready);
	modport sink   (input valid, read_data, tx_valid, tx_byte, rx_accepted, output ready);
endinterface

// ===== hdl/ufb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ufb_ctrl
// Handshake controller: capture a request, execute it, hold the response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ufb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ufb_pkg::ctrl_cmd_t cmd
);
	import ufb_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = (state_q == ST_IDLE) && in_valid;
	assign cmd.exec    = (state_q == ST_RUN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_RUN;
					if (out_ready) out_valid_q <= 1'b0;
				end
				ST_RUN: begin
					if (out_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_cap_exec_excl, clk, arst_n, cmd.capture && cmd.exec,
		"capture and execute overlap")
	`ASSERT_PROP(a_exec_shows, clk, arst_n, cmd.exec |=> out_valid_q && in_ready,
		"executed word not presented")
	`ASSERT_PROP(a_hold_unread, clk, arst_n, (out_valid_q && !out_ready) |=> out_valid_q,
		"response dropped before taken")

endmodule

// ===== hdl/ufb_dpath.sv =====
// ----------------------------------------------------------------------------
// ufb_dpath
// Datapath: FIFO stores, pointers, mode and result registers, response word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ufb_dpath #(
	parameter int FIFO_DEPTH = ufb_pkg::FIFO_DEPTH_DEF,
	parameter int MAX_MODE   = ufb_pkg::MAX_MODE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ufb_pkg::ctrl_cmd_t         cmd,
	input  logic [1:0]                 req_type,
	input  logic [ufb_pkg::DATA_W-1:0] reg_index,
	input  logic [ufb_pkg::DATA_W-1:0] wr_data,
	input  logic [ufb_pkg::DATA_W-1:0] link_byte,
	output logic [ufb_pkg::DATA_W-1:0] read_data,
	output logic                       tx_valid,
	output logic [ufb_pkg::DATA_W-1:0] tx_byte,
	output logic                       rx_accepted
);
	import ufb_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(FIFO_DEPTH);
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(FIFO_DEPTH - 1);
	localparam logic [MODE_W-1:0] MODE_MAX = MODE_W'(MAX_MODE);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] ring_used(input logic [PTR_W-1:0] h,
	                                               input logic [PTR_W-1:0] t);
		logic [CNT_W-1:0] he;
		logic [CNT_W-1:0] te;
		he = {1'b0, h};
		te = {1'b0, t};
		return (h >= t) ? he - te : he + CNT_DEPTH - te;
	endfunction

	// Captured request
	req_kind_t         kind_q;
	logic [DATA_W-1:0] idx_q;
	logic [DATA_W-1:0] wdat_q;
	logic [DATA_W-1:0] lbyte_q;

	// Stores and their registered read ports
	logic [DATA_W-1:0] in_mem  [FIFO_DEPTH];
	logic [DATA_W-1:0] out_mem [FIFO_DEPTH];
	logic [DATA_W-1:0] in_rd_q;
	logic [DATA_W-1:0] out_rd_q;

	// Architectural state
	logic [MODE_W-1:0] mode_q, mode_d;
	logic [DATA_W-1:0] result_q, result_d;
	logic [PTR_W-1:0]  in_head_q, in_head_d, in_tail_q, in_tail_d;
	logic [PTR_W-1:0]  out_head_q, out_head_d, out_tail_q, out_tail_d;

	logic              in_we, out_we;
	logic [DATA_W-1:0] rd_d, txb_d;
	logic              txv_d, rxa_d;
	logic [CNT_W-1:0]  in_used, out_free;
	logic [MODE_W-1:0] new_mode;

	assign in_used  = ring_used(in_head_q, in_tail_q);
	assign out_free = CNT_LAST - ring_used(out_head_q, out_tail_q);
	assign new_mode = wdat_q[MODE_W-1:0];

	always_comb begin
		mode_d     = mode_q;
		result_d   = result_q;
		in_head_d  = in_head_q;
		in_tail_d  = in_tail_q;
		out_head_d = out_head_q;
		out_tail_d = out_tail_q;
		in_we      = 1'b0;
		out_we     = 1'b0;
		rd_d       = '0;
		txv_d      = 1'b0;
		txb_d      = '0;
		rxa_d      = 1'b0;
		unique case (kind_q)
			REQ_HOST_RD: begin
				rd_d = RD_NONE;
				if (mode_q != MODE_OFF) begin
					priority if (idx_q <= REG_DATA_LIM) begin
						if (in_head_q != in_tail_q) begin
							rd_d      = in_rd_q;
							in_tail_d = ptr_next(in_tail_q);
						end
					end else if (idx_q == REG_IN_USED) begin
						rd_d = DATA_W'(in_used);
					end else if (idx_q == REG_OUT_FREE) begin
						rd_d = DATA_W'(out_free);
					end else if (idx_q == REG_CMD) begin
						rd_d = result_q;
					end else begin
						rd_d = RD_NONE;
					end
				end
			end
			REQ_HOST_WR: begin
				if (idx_q == REG_CMD) begin
					priority if ((wdat_q & CMD_MODE_MASK) == CMD_MODE_CODE) begin
						mode_d   = (new_mode > MODE_MAX) ? MODE_OFF : new_mode;
						result_d = RESULT_OK;
					end else if (mode_q != MODE_OFF) begin
						if (wdat_q == CMD_VERSION) begin
							result_d = RESULT_VERSION;
						end else if ((wdat_q & CMD_CLEAR_MASK) == '0) begin
							if (wdat_q[CMD_CLR_IN_BIT]) begin
								in_head_d = '0;
								in_tail_d = '0;
							end
							if (wdat_q[CMD_CLR_OUT_BIT]) begin
								out_head_d = '0;
								out_tail_d = '0;
							end
						end
					end else begin
						mode_d = mode_q;
					end
				end else if (idx_q <= REG_DATA_LIM && mode_q == MODE_DATA) begin
					if (ptr_next(out_head_q) != out_tail_q) begin
						out_we     = 1'b1;
						out_head_d = ptr_next(out_head_q);
					end
				end
			end
			REQ_LINK_RX: begin
				if (ptr_next(in_head_q) != in_tail_q) begin
					in_we     = 1'b1;
					in_head_d = ptr_next(in_head_q);
					rxa_d     = 1'b1;
				end
			end
			REQ_LINK_TX: begin
				if (out_head_q != out_tail_q) begin
					txb_d      = out_rd_q;
					txv_d      = 1'b1;
					out_tail_d = ptr_next(out_tail_q);
				end
			end
			default: rd_d = '0;
		endcase
	end

	// Capture the request and read both stores at their tails
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= req_kind_t'(req_type);
			idx_q    <= reg_index;
			wdat_q   <= wr_data;
			lbyte_q  <= link_byte;
			in_rd_q  <= in_mem[in_tail_q];
			out_rd_q <= out_mem[out_tail_q];
		end
		if (cmd.exec && in_we) in_mem[in_head_q] <= lbyte_q;
		if (cmd.exec && out_we) out_mem[out_head_q] <= wdat_q;
		if (cmd.exec) begin
			read_data   <= rd_d;
			tx_valid    <= txv_d;
			tx_byte     <= txb_d;
			rx_accepted <= rxa_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			result_q   <= RESULT_RESET;
			in_head_q  <= '0;
			in_tail_q  <= '0;
			out_head_q <= '0;
			out_tail_q <= '0;
		end else if (cmd.exec) begin
			mode_q     <= mode_d;
			result_q   <= result_d;
			in_head_q  <= in_head_d;
			in_tail_q  <= in_tail_d;
			out_head_q <= out_head_d;
			out_tail_q <= out_tail_d;
		end
	end

	`ASSERT_PROP(a_ptr_range, clk, arst_n,
		(in_head_q <= PTR_LAST) && (in_tail_q <= PTR_LAST) &&
		(out_head_q <= PTR_LAST) && (out_tail_q <= PTR_LAST),
		"ring pointer beyond depth")
	`ASSERT_PROP(a_ptr_quiet, clk, arst_n,
		!cmd.exec |=> $stable(in_tail_q) && $stable(out_tail_q) &&
		$stable(in_head_q) && $stable(out_head_q),
		"pointer moved outside execute")
	`ASSERT_NEVER(a_one_store, clk, arst_n, cmd.exec && in_we && out_we,
		"one word wrote both stores")

endmodule

// ===== hdl/uart_fifo_bridge_registers.sv =====
// ----------------------------------------------------------------------------
// uart_fifo_bridge_registers
// Register-mapped bridge between a host bus and a serial link.
// ----------------------------------------------------------------------------
// Each request word passes a capture step and an execute step. In the cycle
// it is accepted the block reads both FIFO stores at their tail pointers
// through their registered read ports; in the execute step, once the output
// register is free, it decodes the request, updates mode, result and
// pointers, writes a store if needed and loads the response register. One
// request is in flight at a time: no new word is accepted until the last one
// has executed. A response waiting in the output register does not block
// the next request from being accepted, only from completing. Host reads
// return 0xFF while the block is disabled, on an empty data read and for
// unmapped registers; fields that do not apply to a request are zero. Each
// FIFO holds up to FIFO_DEPTH-1 bytes. No clearing pass runs after reset:
// the stores are only read where the pointers say a byte was written.
// ----------------------------------------------------------------------------
module uart_fifo_bridge_registers #(
	parameter int FIFO_DEPTH = ufb_pkg::FIFO_DEPTH_DEF,
	parameter int MAX_MODE   = ufb_pkg::MAX_MODE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ufb_req_if.sink    req,
	ufb_rsp_if.source  rsp
);
	import ufb_pkg::*;

	ctrl_cmd_t cmd;

	// Sequence the handshake: capture, execute, hold the response word
	ufb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// Hold the FIFOs, pointers and registers; build the response word
	ufb_dpath #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.MAX_MODE   (MAX_MODE)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_type    (req.req_type),
		.reg_index   (req.reg_index),
		.wr_data     (req.wr_data),
		.link_byte   (req.link_byte),
		.read_data   (rsp.read_data),
		.tx_valid    (rsp.tx_valid),
		.tx_byte     (rsp.tx_byte),
		.rx_accepted (rsp.rx_accepted)
	);

endmodule

// ===== verif/bridge_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bridge_scoreboard_pkg
// Reply prediction and checking for the UART FIFO bridge register block.
// ----------------------------------------------------------------------------
package bridge_scoreboard_pkg;

	import ufb_pkg::*;

	localparam int RING_DEPTH = FIFO_DEPTH_DEF;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              tx_valid;
		logic [DATA_W-1:0] tx_byte;
		logic              rx_accepted;
	} bridge_reply_t;

	class bridge_scoreboard;
		logic [MODE_W-1:0] mode;
		logic [DATA_W-1:0] result_byte;
		logic [DATA_W-1:0] out_ring [RING_DEPTH];
		logic [DATA_W-1:0] in_ring [RING_DEPTH];
		int                out_head, out_tail, in_head, in_tail;
		bridge_reply_t     expected_replies [$];
		int                faults;

		function new();
			mode        = MODE_OFF;
			result_byte = RESULT_RESET;
			out_head    = 0;
			out_tail    = 0;
			in_head     = 0;
			in_tail     = 0;
			faults      = 0;
		endfunction

		function int ring_step(int p);
			return (p + 1) % RING_DEPTH;
		endfunction

		function int ring_fill(int head, int tail);
			return (head + RING_DEPTH - tail) % RING_DEPTH;
		endfunction

		// Mode codes always land; version and clear need an active mode.
		function void apply_command(logic [DATA_W-1:0] code);
			if ((code & CMD_MODE_MASK) == CMD_MODE_CODE) begin
				mode        = (code[2:0] > MAX_MODE_DEF) ? MODE_OFF : code[2:0];
				result_byte = RESULT_OK;
			end else if (mode != MODE_OFF) begin
				if (code == CMD_VERSION) begin
					result_byte = RESULT_VERSION;
				end else if ((code & CMD_CLEAR_MASK) == '0) begin
					if (code[CMD_CLR_IN_BIT]) begin
						in_head = 0;
						in_tail = 0;
					end
					if (code[CMD_CLR_OUT_BIT]) begin
						out_head = 0;
						out_tail = 0;
					end
				end
			end
		endfunction

		function bridge_reply_t predict_reply(req_kind_t kind, logic [DATA_W-1:0] idx,
				logic [DATA_W-1:0] wdat, logic [DATA_W-1:0] lbyte);
			bridge_reply_t r;
			r = '0;
			case (kind)
				REQ_HOST_RD: begin
					r.read_data = RD_NONE;
					if (mode != MODE_OFF) begin
						if (idx <= REG_DATA_LIM) begin
							if (in_head != in_tail) begin
								r.read_data = in_ring[in_tail];
								in_tail     = ring_step(in_tail);
							end
						end else if (idx == REG_IN_USED) begin
							r.read_data = DATA_W'(ring_fill(in_head, in_tail));
						end else if (idx == REG_OUT_FREE) begin
							r.read_data = DATA_W'(RING_DEPTH - 1 - ring_fill(out_head, out_tail));
						end else if (idx == REG_CMD) begin
							r.read_data = result_byte;
						end
					end
				end
				REQ_HOST_WR: begin
					if (idx == REG_CMD) begin
						apply_command(wdat);
					end else if (idx <= REG_DATA_LIM && mode == MODE_DATA) begin
						if (ring_step(out_head) != out_tail) begin
							out_ring[out_head] = wdat;
							out_head           = ring_step(out_head);
						end
					end
				end
				REQ_LINK_RX: begin
					if (ring_step(in_head) != in_tail) begin
						in_ring[in_head] = lbyte;
						in_head          = ring_step(in_head);
						r.rx_accepted    = 1'b1;
					end
				end
				default: begin
					if (out_head != out_tail) begin
						r.tx_valid = 1'b1;
						r.tx_byte  = out_ring[out_tail];
						out_tail   = ring_step(out_tail);
					end
				end
			endcase
			return r;
		endfunction

		function void note_request(req_kind_t kind, logic [DATA_W-1:0] idx,
				logic [DATA_W-1:0] wdat, logic [DATA_W-1:0] lbyte);
			expected_replies.push_back(predict_reply(kind, idx, wdat, lbyte));
		endfunction

		function void check_response(bridge_reply_t got);
			bridge_reply_t want;
			if (expected_replies.size() == 0) begin
				$error("reply word with nothing outstanding: %h", got);
				faults++;
				return;
			end
			want = expected_replies.pop_front();
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %h, actual %h", want.read_data, got.read_data);
				faults++;
			end
			if (got.tx_valid !== want.tx_valid) begin
				$error("tx_valid: expected %b, actual %b", want.tx_valid, got.tx_valid);
				faults++;
			end
			if (got.tx_byte !== want.tx_byte) begin
				$error("tx_byte: expected %h, actual %h", want.tx_byte, got.tx_byte);
				faults++;
			end
			if (got.rx_accepted !== want.rx_accepted) begin
				$error("rx_accepted: expected %b, actual %b",
					want.rx_accepted, got.rx_accepted);
				faults++;
			end
		endfunction

		function int outstanding();
			return expected_replies.size();
		endfunction
	endclass

endpackage

// ===== verif/uart_fifo_bridge_registers_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_fifo_bridge_registers_tb
// Drives host accesses and link events into the bridge and checks each reply
// word against a cycle-free prediction of mode, result code and both rings.
// ----------------------------------------------------------------------------
module uart_fifo_bridge_registers_tb;

	import ufb_pkg::*;
	import bridge_scoreboard_pkg::*;

	// Rough share of cycles in which either side holds off
	localparam int IDLE_PCT     = 29;
	// Total request words to issue, directed and random together
	localparam int ITEM_TARGET  = 950;
	// Window of request words during which neither side idles
	localparam int STEADY_FROM  = 450;
	localparam int STEADY_TO    = 600;
	// Cycles with no accepted word before the run is declared hung
	localparam int STALL_LIMIT  = 2000;
	// Settling time once nothing is outstanding
	localparam int SETTLE_CYCLES = 10;
	// Longest fill burst, so that the random phase does not overshoot much
	localparam int FILL_MAX     = RING_DEPTH + 13;

	typedef enum int {
		SEG_FILL_IN,
		SEG_FILL_OUT,
		SEG_DRAIN,
		SEG_MIXED,
		SEG_COMMAND
	} segment_t;

	logic clk = 1'b0;
	logic arst_n;

	ufb_req_if req_ch();
	ufb_rsp_if rsp_ch();

	uart_fifo_bridge_registers u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bridge_scoreboard sb = new();

	int   words_sent = 0;
	int   stall_cycles = 0;
	logic steady;

	assign steady = (words_sent >= STEADY_FROM) && (words_sent < STEADY_TO);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Reply side: drop ready at random, except inside the steady window.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// ------------------------------------------------------------------
	// Monitor: note every accepted request word, check every reply word.
	// Both are sampled at the rising edge, after inputs settled at the
	// falling edge, so the order within the time step does not matter.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		bridge_reply_t seen;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				sb.note_request(req_kind_t'(req_ch.req_type), req_ch.reg_index,
					req_ch.wr_data, req_ch.link_byte);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.read_data   = rsp_ch.read_data;
				seen.tx_valid    = rsp_ch.tx_valid;
				seen.tx_byte     = rsp_ch.tx_byte;
				seen.rx_accepted = rsp_ch.rx_accepted;
				sb.check_response(seen);
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic logic [DATA_W-1:0] rand_byte();
		return DATA_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [DATA_W-1:0] rand_data_reg();
		return DATA_W'($urandom_range(0, REG_DATA_LIM));
	endfunction

	// Pick a command code, biased towards keeping data mode alive and
	// towards the clears that stop the rings sitting full for ever.
	function automatic logic [DATA_W-1:0] pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return CMD_MODE_CODE | DATA_W'(MODE_DATA);
		else if (r < 50)
			return {6'b0, 2'($urandom_range(1, 3))};
		else if (r < 60)
			return CMD_VERSION;
		else if (r < 70)
			return CMD_MODE_CODE | DATA_W'(MODE_OFF);
		else if (r < 80)
			return CMD_MODE_CODE | DATA_W'($urandom_range(2, 7));
		else
			return rand_byte();
	endfunction

	// Present one request word and hold it until the block takes it.
	// Fields that the kind does not use still carry random bits.
	task automatic send_word(req_kind_t kind, logic [DATA_W-1:0] idx,
			logic [DATA_W-1:0] wdat, logic [DATA_W-1:0] lbyte);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= kind;
		req_ch.reg_index <= idx;
		req_ch.wr_data   <= wdat;
		req_ch.link_byte <= lbyte;
		do @(posedge clk); while (!req_ch.ready);
		words_sent++;
	endtask

	task automatic host_read(logic [DATA_W-1:0] idx);
		send_word(REQ_HOST_RD, idx, rand_byte(), rand_byte());
	endtask

	task automatic host_write(logic [DATA_W-1:0] idx, logic [DATA_W-1:0] val);
		send_word(REQ_HOST_WR, idx, val, rand_byte());
	endtask

	task automatic link_rx(logic [DATA_W-1:0] b);
		send_word(REQ_LINK_RX, rand_byte(), rand_byte(), b);
	endtask

	task automatic link_tx();
		send_word(REQ_LINK_TX, rand_byte(), rand_byte(), rand_byte());
	endtask

	// ------------------------------------------------------------------
	// One burst of random traffic of the given flavour. The fill bursts issue
	// more words than the ring depth, mostly ring writes, so drops can be exercised.
	// ------------------------------------------------------------------
	task automatic run_segment(segment_t seg);
		int n;
		int r;
		case (seg)
			SEG_FILL_IN: begin
				n = RING_DEPTH + $urandom_range(0, 12);
				repeat (n) begin
					if ($urandom_range(0, 15) == 0)
						host_read(REG_IN_USED);
					else
						link_rx(rand_byte());
				end
			end
			SEG_FILL_OUT: begin
				host_write(REG_CMD, CMD_MODE_CODE | DATA_W'(MODE_DATA));
				n = RING_DEPTH + $urandom_range(0, 12);
				repeat (n) begin
					if ($urandom_range(0, 15) == 0)
						host_read(REG_OUT_FREE);
					else
						host_write(rand_data_reg(), rand_byte());
				end
			end
			SEG_DRAIN: begin
				n = $urandom_range(20, 80);
				repeat (n) begin
					if ($urandom_range(0, 1))
						host_read(rand_data_reg());
					else
						link_tx();
				end
			end
			SEG_MIXED: begin
				n = $urandom_range(20, 60);
				repeat (n) begin
					r = $urandom_range(0, 99);
					if (r < 30) begin
						r = $urandom_range(0, 9);
						if (r < 6)
							host_read(rand_data_reg());
						else if (r == 6)
							host_read(REG_IN_USED);
						else if (r == 7)
							host_read(REG_OUT_FREE);
						else if (r == 8)
							host_read(REG_CMD);
						else
							host_read(rand_byte());
					end else if (r < 55) begin
						r = $urandom_range(0, 9);
						if (r < 7)
							host_write(rand_data_reg(), rand_byte());
						else if (r < 9)
							host_write(REG_CMD, pick_command());
						else
							host_write(rand_byte(), rand_byte());
					end else if (r < 80) begin
						link_rx(rand_byte());
					end else begin
						link_tx();
					end
				end
			end
			default: begin
				host_write(REG_CMD, pick_command());
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int r;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_HOST_RD;
		req_ch.reg_index = '0;
		req_ch.wr_data   = '0;
		req_ch.link_byte = '0;
		rsp_ch.ready     = 1'b0;
		arst_n           = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Disabled after reset: reads answer the filler, writes do nothing,
		// and neither version nor clear is honoured.
		host_read(8'h00);
		host_read(REG_CMD);
		host_write(8'h00, 8'hA5);
		host_write(REG_CMD, CMD_VERSION);
		host_write(REG_CMD, 8'h03);
		// Mode above the limit falls back to disabled, still answering OK
		host_write(REG_CMD, CMD_MODE_CODE | 8'h07);
		host_write(REG_CMD, CMD_MODE_CODE | DATA_W'(MODE_DATA));
		host_read(REG_CMD);
		host_write(REG_CMD, CMD_VERSION);
		host_read(REG_CMD);
		// Empty rings: data read gives the filler, transmit gives nothing
		host_read(8'h00);
		link_tx();
		host_read(REG_IN_USED);
		host_read(REG_OUT_FREE);
		// Data register extremes, and writes to read-only or unmapped slots
		host_write(REG_DATA_LIM, 8'h00);
		host_write(8'h00, 8'hFF);
		host_write(REG_IN_USED, 8'h5A);
		host_write(8'hFF, 8'hFF);
		link_rx(8'h00);
		link_rx(8'hFF);
		host_read(8'hC2);
		host_read(8'hC6);
		host_read(8'hC8);
		host_read(8'hFF);
		host_read(REG_DATA_LIM);
		link_tx();
		// A code that matches nothing, then clears of no ring, the in ring and the out ring
		host_write(REG_CMD, 8'h04);
		host_write(REG_CMD, 8'h00);
		host_write(REG_CMD, 8'h01);
		host_write(REG_CMD, 8'h02);

		// Run one fill burst on each ring, then wander at random.
		// Near the end, keep to short bursts so the total stays close.
		run_segment(SEG_FILL_IN);
		run_segment(SEG_FILL_OUT);
		while (words_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				run_segment(SEG_MIXED);
			else if (r < 70)
				run_segment(SEG_DRAIN);
			else if (r < 92)
				run_segment(SEG_COMMAND);
			else if (words_sent + FILL_MAX >= ITEM_TARGET)
				run_segment(SEG_MIXED);
			else if (r < 96)
				run_segment(SEG_FILL_IN);
			else
				run_segment(SEG_FILL_OUT);
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;

		// Hold until every reply is in, then let the pipe settle so that a
		// stray extra word would still be caught.
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.faults == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ufb_pkg.sv
hdl/ufb_req_if.sv
hdl/ufb_rsp_if.sv
hdl/ufb_ctrl.sv
hdl/ufb_dpath.sv
hdl/uart_fifo_bridge_registers.sv
verif/bridge_scoreboard_pkg.sv
verif/uart_fifo_bridge_registers_tb.sv
